// ----- design/lfukv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfukv_pkg: shared types and constants of the LFU key-value cache
// Request and response payloads, stored entry layout, controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lfukv_pkg;

  localparam int CfgW   = 5;
  localparam int DataW  = 32;
  localparam int CountW = 32;
  localparam int StampW = 64;

  localparam logic [CfgW-1:0]   CapacityReset = 5'd16;
  localparam logic [DataW-1:0]  MissValue     = '1;
  localparam logic [CountW-1:0] CountMax      = '1;
  localparam logic [CountW-1:0] CountFirst    = 32'd1;

  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [DataW-1:0] evicted_key;
  } rsp_t;

  typedef struct packed {
    logic [DataW-1:0]  key;
    logic [DataW-1:0]  value;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StTail,
    StCommit
  } state_e;

  typedef struct packed {
    logic start;   // latch request, clear search results
    logic scan;    // read next entry
    logic commit;  // update entry and load result
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/lfukv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfukv_ctrl: request sequencer
// Accepts one request, sweeps all entries, waits for the last compare,
// then commits the update once the result register is free.
// ----------------------------------------------------------------------------
module lfukv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfukv_pkg::sts_t  sts_i,
  output lfukv_pkg::cmd_t  cmd_o
);

  lfukv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfukv_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lfukv_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = lfukv_pkg::StScan;
        end
      end
      lfukv_pkg::StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = lfukv_pkg::StTail;
        end
      end
      lfukv_pkg::StTail: begin
        // last read data lands in the compare stage
        state_d = lfukv_pkg::StCommit;
      end
      lfukv_pkg::StCommit: begin
        // hold until the previous result has been taken
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = lfukv_pkg::StIdle;
        end
      end
      default: begin
        state_d = lfukv_pkg::StIdle;
      end
    endcase
  end

endmodule

// ----- design/lfukv_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfukv_dpath: entry store, search and update datapath
// Holds the entry memory, valid bits, occupancy, time stamp and capacity;
// scans entries one per cycle for key match, victim and free slot.
// ----------------------------------------------------------------------------
module lfukv_dpath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lfukv_pkg::CfgW-1:0]       cfg_data_i,
  input  lfukv_pkg::req_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lfukv_pkg::rsp_t                  out_data_o,
  input  lfukv_pkg::cmd_t                  cmd_i,
  output lfukv_pkg::sts_t                  sts_o
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OccW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (OccW > lfukv_pkg::CfgW) ? OccW : lfukv_pkg::CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTRIES - 1);
  localparam logic [CmpW-1:0] MaxCap  = CmpW'(MAX_ENTRIES);

  // control state
  logic [lfukv_pkg::CfgW-1:0] capacity_q;
  logic [MAX_ENTRIES-1:0]     valid_q, valid_d;
  logic [OccW-1:0]            occ_q, occ_d;
  logic [lfukv_pkg::StampW-1:0] time_q, time_d;
  logic                       out_valid_q;
  logic                       cmp_vld_q;
  logic                       match_q, victim_vld_q, free_vld_q;
  logic [IdxW-1:0]            scan_cnt_q;

  // payload state
  lfukv_pkg::entry_t                 entry_mem_q [MAX_ENTRIES];
  lfukv_pkg::entry_t                 rd_data_q;
  lfukv_pkg::req_t                   req_q;
  lfukv_pkg::rsp_t                   out_data_q, rsp_d;
  logic [IdxW-1:0]                   cmp_idx_q;
  logic [IdxW-1:0]                   match_idx_q, victim_idx_q, free_idx_q;
  logic [lfukv_pkg::DataW-1:0]       hit_value_q, victim_key_q;
  logic [lfukv_pkg::CountW-1:0]      hit_count_q, victim_count_q;
  logic [lfukv_pkg::StampW-1:0]      victim_stamp_q;

  // compare stage
  logic cur_valid, key_hit, older;

  // commit decisions
  logic [CmpW-1:0]              cap_eff;
  logic                         is_put, cap_zero, need_evict, do_insert, do_touch;
  logic                         mem_we;
  logic [IdxW-1:0]              wr_addr;
  lfukv_pkg::entry_t            wr_data;
  logic [lfukv_pkg::CountW-1:0] count_inc;

  assign sts_o.scan_last = (scan_cnt_q == LastIdx);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

  assign cur_valid = valid_q[cmp_idx_q];
  assign key_hit   = cur_valid && (rd_data_q.key == req_q.key);
  assign older     = {rd_data_q.count, rd_data_q.stamp} < {victim_count_q, victim_stamp_q};

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.scan) begin
      rd_data_q <= entry_mem_q[scan_cnt_q];
    end
  end

  always_comb begin
    cap_eff    = (CmpW'(capacity_q) > MaxCap) ? MaxCap : CmpW'(capacity_q);
    is_put     = (req_q.req_type == lfukv_pkg::ReqPut);
    cap_zero   = (cap_eff == '0);
    count_inc  = (hit_count_q == lfukv_pkg::CountMax) ? hit_count_q : hit_count_q + 1'b1;
    need_evict = is_put && !cap_zero && !match_q && victim_vld_q &&
                 (CmpW'(occ_q) >= cap_eff);
    do_insert  = is_put && !cap_zero && !match_q && (need_evict || free_vld_q);
    do_touch   = match_q && (!is_put || !cap_zero);

    valid_d = valid_q;
    occ_d   = occ_q;
    time_d  = time_q;
    mem_we  = 1'b0;
    wr_addr = match_idx_q;
    wr_data.key   = req_q.key;
    wr_data.value = is_put ? req_q.value : hit_value_q;
    wr_data.count = count_inc;
    wr_data.stamp = time_q;

    if (do_touch) begin
      mem_we = cmd_i.commit;
    end else if (do_insert) begin
      mem_we        = cmd_i.commit;
      wr_addr       = need_evict ? victim_idx_q : free_idx_q;
      wr_data.value = req_q.value;
      wr_data.count = lfukv_pkg::CountFirst;
      // an eviction frees and refills the same slot: occupancy holds
      if (!need_evict && (occ_q < OccW'(MAX_ENTRIES))) begin
        occ_d = occ_q + 1'b1;
      end
    end

    if (mem_we) begin
      valid_d[wr_addr] = 1'b1;
      time_d           = time_q + 1'b1;
    end

    rsp_d.found       = match_q;
    rsp_d.read_value  = is_put ? '0 : (match_q ? hit_value_q : lfukv_pkg::MissValue);
    rsp_d.evicted     = need_evict;
    rsp_d.evicted_key = need_evict ? victim_key_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= lfukv_pkg::CapacityReset;
      valid_q      <= '0;
      occ_q        <= '0;
      time_q       <= '0;
      out_valid_q  <= 1'b0;
      cmp_vld_q    <= 1'b0;
      match_q      <= 1'b0;
      victim_vld_q <= 1'b0;
      free_vld_q   <= 1'b0;
      scan_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      cmp_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_cnt_q   <= '0;
        match_q      <= 1'b0;
        victim_vld_q <= 1'b0;
        free_vld_q   <= 1'b0;
      end else begin
        if (cmd_i.scan && !sts_o.scan_last) begin
          scan_cnt_q <= scan_cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (key_hit) begin
            match_q <= 1'b1;
          end
          if (cur_valid && (!victim_vld_q || older)) begin
            victim_vld_q <= 1'b1;
          end
          if (!cur_valid) begin
            free_vld_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit) begin
        valid_q     <= valid_d;
        occ_q       <= occ_d;
        time_q      <= time_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search results and result register
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= scan_cnt_q;
    if (cmd_i.start) begin
      req_q <= in_data_i;
    end
    if (cmp_vld_q && !cmd_i.start) begin
      if (key_hit && !match_q) begin
        match_idx_q <= cmp_idx_q;
        hit_value_q <= rd_data_q.value;
        hit_count_q <= rd_data_q.count;
      end
      // strict compare keeps the lowest index on a full tie
      if (cur_valid && (!victim_vld_q || older)) begin
        victim_idx_q   <= cmp_idx_q;
        victim_key_q   <= rd_data_q.key;
        victim_count_q <= rd_data_q.count;
        victim_stamp_q <= rd_data_q.stamp;
      end
      if (!cur_valid && !free_vld_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (cmd_i.commit) begin
      out_data_q <= rsp_d;
    end
  end

endmodule

// ----- design/lfu_key_value_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_key_value_cache_core: key-value cache with LFU replacement
// Least-frequently-used eviction, least-recently-used among equal counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (get or put) enter on the in_* valid/ready channel, one result
//   per request leaves on the out_* channel. The capacity register is
//   written on the cfg_* channel, which is always ready; write it only while
//   no request is in flight.
//   Each request is handled in steps: the entry memory has one read port, so
//   the key match, victim search and free-slot search sweep it one entry per
//   cycle, then a tail state drains the compare stage and a commit state
//   writes the entry and loads the result register.
//   The block takes one request at a time and accepts the next only once it
//   is back in idle after the commit; a new request is accepted while the
//   previous result still waits in the output register.
//   If the receiver stalls, the commit of the next request holds until the
//   waiting result is taken.
//   Reset clears all valid bits, occupancy and the time stamp, sets the
//   capacity to 16 and leaves the entry memory contents undefined.
// ----------------------------------------------------------------------------
module lfu_key_value_cache_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfukv_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lfukv_pkg::req_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lfukv_pkg::rsp_t              out_data_o
);

  lfukv_pkg::cmd_t cmd;
  lfukv_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lfukv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfukv_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTH
  // one request at a time: busy right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  // a commit never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result register overwritten");

  // a new search starts only on an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> in_valid_i && in_ready_o)
    else $error("search started without request");

  // results appear only after a commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result valid without commit");
`endif

endmodule
